### rtl/ed_pkg.sv
// shared constants for the edit distance core
// no dependencies

package ed_pkg;

    localparam int MAX_LEN_DEF = 1024;
    localparam int SYM_W       = 8;
    localparam int DIST_W      = 11;

endpackage

### rtl/edit_distance_core.sv
// edit distance core: string stores, single row buffer and cell sequencer
// depends on ed_pkg and ed_cell

// Loading takes one word per cycle while busy is low: each accepted word may
// append a byte to the first or second string (bytes beyond MAX_LEN are
// dropped and flagged). A word with last_item set ends the pair and raises
// busy while the distance is worked out by one shared cell unit, one matrix
// cell per cycle within a row, over a single row memory with one read and one
// write port. The result is shown for exactly one cycle with done high; there
// is no hold-off from the receiver, so it must be taken in that cycle. Lengths
// and the overflow flag clear as the result goes out.

module edit_distance_core #(
    parameter int MAX_LEN = ed_pkg::MAX_LEN_DEF
) (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      start,
    output logic                      busy,
    input  logic [ed_pkg::SYM_W-1:0]  symbol,
    input  logic                      second_string,
    input  logic                      has_symbol,
    input  logic                      last_item,
    output logic                      done,
    output logic [ed_pkg::DIST_W-1:0] distance,
    output logic                      too_long
);
    import ed_pkg::*;

    localparam int LEN_W  = $clog2(MAX_LEN + 1);
    localparam int ADDR_W = (MAX_LEN > 1) ? $clog2(MAX_LEN) : 1;

    typedef enum logic [2:0] {
        IDLE,
        CHECK,
        INIT,
        FETCH,
        ROW
    } state_t;

    state_t              state_reg, state_next;
    logic [LEN_W-1:0]    first_len_reg, first_len_next;
    logic [LEN_W-1:0]    second_len_reg, second_len_next;
    logic                ovf_reg, ovf_next;
    logic [LEN_W-1:0]    row_reg, row_next;
    logic [ADDR_W-1:0]   col_reg, col_next;
    logic [LEN_W-1:0]    diag_reg, diag_next;
    logic [LEN_W-1:0]    left_reg, left_next;
    logic                done_reg, done_next;
    logic [DIST_W-1:0]   dist_reg, dist_next;
    logic                too_long_reg, too_long_next;

    logic [SYM_W-1:0]    first_store [MAX_LEN];
    logic [SYM_W-1:0]    second_store [MAX_LEN];
    logic [LEN_W-1:0]    row_mem [MAX_LEN];

    logic [SYM_W-1:0]    a_q;
    logic [SYM_W-1:0]    b_q;
    logic [LEN_W-1:0]    up_q;

    logic                fs_we;
    logic                ss_we;
    logic                row_we;
    logic [LEN_W-1:0]    row_wd;
    logic [ADDR_W-1:0]   rd_addr;
    logic [LEN_W-1:0]    row_dec;
    logic [ADDR_W-1:0]   sec_ra;
    logic [LEN_W-1:0]    cell_cost;
    logic                last_col;
    logic                accept;

    assign accept   = start && (state_reg == IDLE);
    assign row_dec  = row_reg - 1'b1;
    assign sec_ra   = row_dec[ADDR_W-1:0];
    assign last_col = (LEN_W'(col_reg) == (first_len_reg - 1'b1));

    assign fs_we = accept && has_symbol && !second_string
                   && (first_len_reg < LEN_W'(MAX_LEN));
    assign ss_we = accept && has_symbol && second_string
                   && (second_len_reg < LEN_W'(MAX_LEN));

    ed_cell #(
        .W (LEN_W)
    ) u_cell (
        .up   (up_q),
        .diag (diag_reg),
        .left (left_reg),
        .a    (a_q),
        .b    (b_q),
        .cost (cell_cost)
    );

    always_comb
    begin
        state_next      = state_reg;
        first_len_next  = first_len_reg;
        second_len_next = second_len_reg;
        ovf_next        = ovf_reg;
        row_next        = row_reg;
        col_next        = col_reg;
        diag_next       = diag_reg;
        left_next       = left_reg;
        done_next       = 1'b0;
        dist_next       = dist_reg;
        too_long_next   = too_long_reg;
        row_we          = 1'b0;
        row_wd          = cell_cost;
        rd_addr         = col_reg + ADDR_W'(1);

        case (state_reg)
            IDLE:
            begin
                if (accept)
                begin
                    if (fs_we)
                        first_len_next = first_len_reg + 1'b1;
                    if (ss_we)
                        second_len_next = second_len_reg + 1'b1;
                    if (has_symbol && !fs_we && !ss_we)
                        ovf_next = 1'b1;
                    if (last_item)
                        state_next = CHECK;
                end
            end
            CHECK:
            begin
                col_next = '0;
                if ((first_len_reg == '0) || (second_len_reg == '0))
                begin
                    done_next       = 1'b1;
                    dist_next       = (first_len_reg == '0) ? DIST_W'(second_len_reg)
                                                            : DIST_W'(first_len_reg);
                    too_long_next   = ovf_reg;
                    first_len_next  = '0;
                    second_len_next = '0;
                    ovf_next        = 1'b0;
                    state_next      = IDLE;
                end
                else
                begin
                    state_next = INIT;
                end
            end
            INIT:
            begin
                row_we = 1'b1;
                row_wd = LEN_W'(col_reg) + 1'b1;
                if (last_col)
                begin
                    row_next   = LEN_W'(1);
                    state_next = FETCH;
                end
                else
                begin
                    col_next = col_reg + ADDR_W'(1);
                end
            end
            FETCH:
            begin
                rd_addr    = '0;
                diag_next  = row_dec;
                left_next  = row_reg;
                col_next   = '0;
                state_next = ROW;
            end
            ROW:
            begin
                row_we    = 1'b1;
                diag_next = up_q;
                left_next = cell_cost;
                if (last_col)
                begin
                    if (row_reg == second_len_reg)
                    begin
                        done_next       = 1'b1;
                        dist_next       = DIST_W'(cell_cost);
                        too_long_next   = ovf_reg;
                        first_len_next  = '0;
                        second_len_next = '0;
                        ovf_next        = 1'b0;
                        state_next      = IDLE;
                    end
                    else
                    begin
                        row_next   = row_reg + 1'b1;
                        state_next = FETCH;
                    end
                end
                else
                begin
                    col_next = col_reg + ADDR_W'(1);
                end
            end
            default:
            begin
                state_next = IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= IDLE;
            first_len_reg  <= '0;
            second_len_reg <= '0;
            ovf_reg        <= 1'b0;
            row_reg        <= '0;
            col_reg        <= '0;
            done_reg       <= 1'b0;
            dist_reg       <= '0;
            too_long_reg   <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            first_len_reg  <= first_len_next;
            second_len_reg <= second_len_next;
            ovf_reg        <= ovf_next;
            row_reg        <= row_next;
            col_reg        <= col_next;
            done_reg       <= done_next;
            dist_reg       <= dist_next;
            too_long_reg   <= too_long_next;
        end
    end

    always_ff @(posedge clk)
    begin
        diag_reg <= diag_next;
        left_reg <= left_next;
    end

    always_ff @(posedge clk)
    begin
        if (fs_we)
            first_store[first_len_reg[ADDR_W-1:0]] <= symbol;
        a_q <= first_store[rd_addr];
    end

    always_ff @(posedge clk)
    begin
        if (ss_we)
            second_store[second_len_reg[ADDR_W-1:0]] <= symbol;
        b_q <= second_store[sec_ra];
    end

    always_ff @(posedge clk)
    begin
        if (row_we)
            row_mem[col_reg] <= row_wd;
        up_q <= row_mem[rd_addr];
    end

    assign busy     = (state_reg != IDLE);
    assign done     = done_reg;
    assign distance = dist_reg;
    assign too_long = too_long_reg;

    a_done_single : assert property (@(posedge clk) disable iff (!rst_n)
        done_reg |=> !done_reg)
        else $error("result strobe held for more than one cycle");

    a_last_busy : assert property (@(posedge clk) disable iff (!rst_n)
        (accept && last_item) |=> busy)
        else $error("end of pair did not start the distance pass");

    a_len_bound : assert property (@(posedge clk) disable iff (!rst_n)
        (first_len_reg <= LEN_W'(MAX_LEN)) && (second_len_reg <= LEN_W'(MAX_LEN)))
        else $error("string length beyond store depth");

    a_col_bound : assert property (@(posedge clk) disable iff (!rst_n)
        ((state_reg == ROW) || (state_reg == INIT)) |-> (LEN_W'(col_reg) < first_len_reg))
        else $error("column index beyond first string");

    a_row_bound : assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ROW) |-> ((row_reg != '0) && (row_reg <= second_len_reg)))
        else $error("row index outside second string");

endmodule

### rtl/ed_cell.sv
// one cell of the distance matrix: min of insert, delete and substitute cost
// depends on ed_pkg

module ed_cell #(
    parameter int W = 11
) (
    input  logic [W-1:0]            up,
    input  logic [W-1:0]            diag,
    input  logic [W-1:0]            left,
    input  logic [ed_pkg::SYM_W-1:0] a,
    input  logic [ed_pkg::SYM_W-1:0] b,
    output logic [W-1:0]            cost
);
    import ed_pkg::*;

    logic [W:0] ins_cost;
    logic [W:0] del_cost;
    logic [W:0] sub_cost;
    logic [W:0] min_ab;
    logic [W:0] min_all;

    assign ins_cost = {1'b0, up} + 1'b1;
    assign del_cost = {1'b0, left} + 1'b1;
    assign sub_cost = {1'b0, diag} + ((a != b) ? 1'b1 : 1'b0);

    always_comb
    begin
        min_ab  = (ins_cost < del_cost) ? ins_cost : del_cost;
        min_all = (min_ab < sub_cost) ? min_ab : sub_cost;
    end

    assign cost = min_all[W-1:0];

endmodule
